// File: design/dtq_pkg.sv
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int DL_W        = 64;
    localparam int RES_W       = 20;
    localparam int ACT_W       = 2;
    localparam int OUT_ID_W    = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_CANCEL   = 2'd1,
        ACT_TICK     = 2'd2
    } t_action;

    // one slot of the sorted chain
    typedef struct packed {
        logic            valid;
        logic [DL_W-1:0] deadline;
        logic [ID_BITS-1:0] id;
    } t_entry;

    // broadcast to every cell; id doubles as the cancel key
    typedef struct packed {
        logic            ins;
        logic            rem;
        logic            pop;
        logic [DL_W-1:0] deadline;
        logic [ID_BITS-1:0] id;
    } t_cell_ctrl;

endpackage

// File: design/dtq_cell.sv
`timescale 1ns / 1ps

module dtq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtq_pkg::t_cell_ctrl i_ctrl,
    input  dtq_pkg::t_entry    i_prev,
    input  dtq_pkg::t_entry    i_next,
    input  logic               i_prev_after,
    input  logic               i_hit_before,
    output dtq_pkg::t_entry    o_ent,
    output logic               o_after,
    output logic               o_match
);
    import dtq_pkg::*;

    logic               r_valid;
    logic [DL_W-1:0]    r_deadline;
    logic [ID_BITS-1:0] r_id;
    t_entry             n_ent;

    assign o_ent   = '{valid: r_valid, deadline: r_deadline, id: r_id};
    // new entry goes behind this one (ties keep arrival order)
    assign o_after = r_valid && (r_deadline <= i_ctrl.deadline);
    assign o_match = r_valid && (r_id == i_ctrl.id);

    always_comb begin
        n_ent = o_ent;
        if (i_ctrl.ins) begin
            if (!o_after) begin
                if (i_prev_after) begin
                    n_ent = '{valid: 1'b1, deadline: i_ctrl.deadline, id: i_ctrl.id};
                end else begin
                    n_ent = i_prev;
                end
            end
        end else if (i_ctrl.rem) begin
            // compact from the first match onward
            if (i_hit_before || o_match) begin
                n_ent = i_next;
            end
        end else if (i_ctrl.pop) begin
            n_ent = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_ent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deadline <= n_ent.deadline;
        r_id       <= n_ent.id;
    end

endmodule

// File: design/deadline_timer_queue.sv
`timescale 1ns / 1ps

// Sorted timer queue: up to QUEUE_DEPTH timers held in deadline order in a
// chain of cells, equal deadlines in arrival order.
// Input stream (s side): one word per command. tdata carries the action
// (schedule, cancel, tick), timer id, time value and current time; tuser
// says whether a schedule's time value is absolute or a delay from now.
// Output stream (m side): exactly one result word per command, in order:
// scheduled deadline, fired id and next head deadline in tdata, and the
// accepted / cancel_found / fired flags in tuser.
// Config: i_cfg_we writes the 20-bit early-fire margin added to now on a
// tick; write it only while no command is in flight.
// Pipeline: an accepted word goes through a prep stage for the 64-bit
// adds, then the cell update with the output register.
// Throughput: one command per cycle unless the m side stalls; every cell
// compares and shifts in the same cycle for insert, cancel-and-compact and pop.
// Stall: when the m side holds tready low, the output register keeps its
// word, one more command waits in the prep stage, then s tready drops.
// Reset (sync, active low): queue empty, margin 0, both stages empty.
// Stored deadlines and ids are not cleared; only the per-cell valid bits.
module deadline_timer_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [19:0]   i_cfg_wdata,    // early-fire margin
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // action[1:0], timer_id[17:2], time_value[81:18], now_time[145:82], pad
    input  logic [151:0]  i_s_tdata,
    input  logic          i_s_tuser,      // absolute
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // scheduled_time[63:0], fired_id[79:64], next_deadline[143:80]
    output logic [143:0]  o_m_tdata,
    // accepted[0], cancel_found[1], fired[2]
    output logic [2:0]    o_m_tuser
);
    import dtq_pkg::*;

    // ---------------- config
    logic [RES_W-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (i_cfg_we) begin
            r_res <= i_cfg_wdata;
        end
    end

    // ---------------- input field split
    logic [ACT_W-1:0]  w_in_action;
    logic [15:0]       w_in_id;
    logic [DL_W-1:0]   w_in_tval;
    logic [DL_W-1:0]   w_in_now;

    assign w_in_action = i_s_tdata[1:0];
    assign w_in_id     = i_s_tdata[17:2];
    assign w_in_tval   = i_s_tdata[81:18];
    assign w_in_now    = i_s_tdata[145:82];

    // ---------------- prep stage: the two 64-bit adds
    logic               r_a_valid;
    logic [ACT_W-1:0]   r_a_action;
    logic [ID_BITS-1:0] r_a_id;
    logic [DL_W-1:0]    r_a_sched;
    logic [DL_W-1:0]    r_a_due;     // now + margin, wraps
    logic               r_o_valid;
    logic               w_adv;

    assign w_adv      = r_a_valid && (!r_o_valid || i_m_tready);
    assign o_s_tready = !r_a_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_a_action <= w_in_action;
            r_a_id     <= ID_BITS'(w_in_id);
            r_a_sched  <= i_s_tuser ? w_in_tval : (w_in_tval + w_in_now);
            r_a_due    <= w_in_now + DL_W'(r_res);
        end
    end

    // ---------------- cell chain
    t_entry                  w_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  w_after;
    logic [QUEUE_DEPTH-1:0]  w_match;
    logic [QUEUE_DEPTH-1:0]  w_valid_vec;
    t_cell_ctrl              w_ctrl;
    t_action                 w_act;
    logic                    w_full;
    logic                    w_due;

    assign w_act  = t_action'(r_a_action);
    assign w_full = w_ent[QUEUE_DEPTH-1].valid;
    assign w_due  = w_ent[0].valid && (r_a_due > w_ent[0].deadline);

    always_comb begin
        w_ctrl          = '0;
        w_ctrl.deadline = r_a_sched;
        w_ctrl.id       = r_a_id;
        case (w_act)
            ACT_SCHEDULE: w_ctrl.ins = w_adv && !w_full;
            ACT_CANCEL:   w_ctrl.rem = w_adv;
            ACT_TICK:     w_ctrl.pop = w_adv && w_due;
            default: ;
        endcase
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_after;
        logic   w_hit_before;

        if (g == 0) begin : g_first
            assign w_prev       = '0;
            assign w_prev_after = 1'b1;
            assign w_hit_before = 1'b0;
        end else begin : g_mid
            assign w_prev       = w_ent[g-1];
            assign w_prev_after = w_after[g-1];
            // any earlier cell matched: OR tree over lower cells
            assign w_hit_before = |w_match[g-1:0];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_ent[g+1];
        end

        dtq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev       (w_prev),
            .i_next       (w_next),
            .i_prev_after (w_prev_after),
            .i_hit_before (w_hit_before),
            .o_ent        (w_ent[g]),
            .o_after      (w_after[g]),
            .o_match      (w_match[g])
        );

        assign w_valid_vec[g] = w_ent[g].valid;
    end

    // head after this command's update
    t_entry w_head;

    always_comb begin
        if (w_ctrl.pop || (w_ctrl.rem && w_match[0])) begin
            w_head = w_ent[1];
        end else if (w_ctrl.ins && !w_after[0]) begin
            w_head = '{valid: 1'b1, deadline: r_a_sched, id: r_a_id};
        end else begin
            w_head = w_ent[0];
        end
    end

    // ---------------- result word
    logic [DL_W-1:0]     w_res_sched;
    logic                w_res_acc;
    logic                w_res_found;
    logic                w_res_fired;
    logic [OUT_ID_W-1:0] w_res_fid;

    always_comb begin
        w_res_sched = '0;
        w_res_acc   = 1'b0;
        w_res_found = 1'b0;
        w_res_fired = 1'b0;
        w_res_fid   = '0;
        case (w_act)
            ACT_SCHEDULE: begin
                w_res_sched = r_a_sched;
                w_res_acc   = !w_full;
            end
            ACT_CANCEL: begin
                w_res_found = |w_match;
            end
            ACT_TICK: begin
                w_res_fired = w_due;
                w_res_fid   = w_due ? OUT_ID_W'(w_ent[0].id) : '0;
            end
            default: ;
        endcase
    end

    logic [DL_W-1:0]     r_o_sched;
    logic [OUT_ID_W-1:0] r_o_fid;
    logic [DL_W-1:0]     r_o_next;
    logic [2:0]          r_o_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_sched <= w_res_sched;
            r_o_fid   <= w_res_fid;
            r_o_next  <= w_head.valid ? w_head.deadline : '0;
            r_o_flags <= {w_res_fired, w_res_found, w_res_acc};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_next, r_o_fid, r_o_sched};
    assign o_m_tuser  = r_o_flags;

    // ---------------- checks
    logic [QUEUE_DEPTH-2:0] w_order_bad;

    for (genvar k = 0; k < QUEUE_DEPTH - 1; k++) begin : g_order
        assign w_order_bad[k] = w_ent[k+1].valid
                             && (w_ent[k+1].deadline < w_ent[k].deadline);
    end

    // occupied cells form a solid run from the head
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(QUEUE_DEPTH'(w_valid_vec + 1'b1)))
        else $error("queue has a hole in its valid cells");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_order_bad == '0)
        else $error("queue entries out of deadline order");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $onehot0(r_o_flags))
        else $error("result carries flags of more than one action");

    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |=> (r_o_valid && r_o_flags[2]))
        else $error("popped head without a fired result");

endmodule

// File: tb/sv/tb_deadline_timer_queue.sv
`timescale 1ns / 1ps

// Self-checking bench for the sorted timer queue.
// Each command word the block accepts is run through a local copy of the
// queue (deadline order, ties in arrival order), and the resulting word is
// pushed onto a list of pending results. A monitor pops that list on every
// result word and compares the fields one by one. Both stream sides stall
// at random, apart from one long burst with no stalls.
module tb_deadline_timer_queue;
    import dtq_pkg::*;

    // action code 3 is not in the package enum; the block must ignore it
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;  // watchdog bound on the run length
    localparam int SETTLE_CYCLES = 6;      // idle wait once all results are back

    typedef struct packed {
        logic [DL_W-1:0]     sched;
        logic                accepted;
        logic                cancel_found;
        logic                fired;
        logic [OUT_ID_W-1:0] fired_id;
        logic [DL_W-1:0]     next_deadline;
    } t_timer_result;

    // ---------------------------------------------------------------
    // DUT signals
    // ---------------------------------------------------------------
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_cfg_we    = 1'b0;
    logic [19:0]   i_cfg_wdata = '0;
    logic          i_s_tvalid  = 1'b0;
    logic          o_s_tready;
    // action[1:0], timer_id[17:2], time_value[81:18], now_time[145:82], pad
    logic [151:0]  i_s_tdata   = '0;
    logic          i_s_tuser   = 1'b0;   // absolute
    logic          o_m_tvalid;
    logic          i_m_tready  = 1'b0;
    // scheduled_time[63:0], fired_id[79:64], next_deadline[143:80]
    logic [143:0]  o_m_tdata;
    // accepted[0], cancel_found[1], fired[2]
    logic [2:0]    o_m_tuser;

    deadline_timer_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Local copy of the timer queue
    // ---------------------------------------------------------------
    logic [DL_W-1:0]    tq_deadline [QUEUE_DEPTH];
    logic [ID_BITS-1:0] tq_id       [QUEUE_DEPTH];
    int                 tq_count = 0;
    logic [RES_W-1:0]   margin   = '0;      // early-fire margin, reset 0

    t_timer_result pending_results [$];

    // bench bookkeeping
    int  err_count     = 0;
    int  words_sent    = 0;
    int  results_seen  = 0;
    int  n_fired       = 0;
    int  n_cancel_hits = 0;
    int  n_full_reject = 0;
    int  n_margins     = 1;
    int  cycles        = 0;
    bit  src_idle      = 1'b1;
    bit  snk_idle      = 1'b1;

    // stimulus state: a clock that mostly moves forward, a pool of ids
    logic [DL_W-1:0]    cur_now       = '0;
    logic [DL_W-1:0]    last_deadline = '0;
    logic [ID_BITS-1:0] id_pool [8];

    // close the gap at pos, shifting later entries down by one
    task automatic remove_entry(input int pos);
        int k;
        for (k = pos; k + 1 < tq_count; k++) begin
            tq_deadline[k] = tq_deadline[k+1];
            tq_id[k]       = tq_id[k+1];
        end
        tq_count--;
    endtask

    // apply one accepted command to the local queue and queue its result
    task automatic predict_result(input logic [ACT_W-1:0] act, input logic [ID_BITS-1:0] id,
                                  input logic [DL_W-1:0] tval, input logic absol,
                                  input logic [DL_W-1:0] now);
        t_timer_result   r;
        int              pos;
        int              k;
        logic [DL_W-1:0] due;
        r = '0;
        if (act == ACT_SCHEDULE) begin
            r.sched = absol ? tval : tval + now;   // wraps mod 2^64
            if (tq_count < QUEUE_DEPTH) begin
                pos = 0;
                // ties go behind existing entries
                while (pos < tq_count && tq_deadline[pos] <= r.sched)
                    pos++;
                for (k = tq_count; k > pos; k--) begin
                    tq_deadline[k] = tq_deadline[k-1];
                    tq_id[k]       = tq_id[k-1];
                end
                tq_deadline[pos] = r.sched;
                tq_id[pos]       = id;
                tq_count++;
                r.accepted = 1'b1;
            end else begin
                n_full_reject++;
            end
        end else if (act == ACT_CANCEL) begin
            for (k = 0; k < tq_count; k++) begin
                if (!r.cancel_found && tq_id[k] == id) begin
                    remove_entry(k);
                    r.cancel_found = 1'b1;
                    n_cancel_hits++;
                end
            end
        end else if (act == ACT_TICK) begin
            due = now + DL_W'(margin);
            if (tq_count > 0 && due > tq_deadline[0]) begin
                r.fired    = 1'b1;
                r.fired_id = tq_id[0];
                remove_entry(0);
                n_fired++;
            end
        end
        r.next_deadline = (tq_count > 0) ? tq_deadline[0] : '0;
        pending_results.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // Source side: one command word per call. Called at a falling edge,
    // returns at a falling edge with tvalid still high; the next call (or
    // stop_source) decides its value, so it is assigned once per step.
    // ---------------------------------------------------------------
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [15:0] id,
                             input logic [DL_W-1:0] tval, input logic absol,
                             input logic [DL_W-1:0] now);
        while (src_idle && $urandom_range(0, 99) < 38) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, now, tval, id, act};
        i_s_tuser  <= absol;
        do @(posedge i_clk); while (!o_s_tready);
        predict_result(act, id[ID_BITS-1:0], tval, absol, now);
        words_sent++;
        @(negedge i_clk);
    endtask

    // pause the source until every result is back, then let the pipe settle
    task automatic stop_source();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // margin register: only written with the block idle
    task automatic write_margin(input logic [RES_W-1:0] value);
        stop_source();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        margin       = value;
        n_margins++;
    endtask

    // ---------------------------------------------------------------
    // Sink side and result monitor
    // ---------------------------------------------------------------
    always @(negedge i_clk)
        i_m_tready <= snk_idle ? ($urandom_range(0, 99) >= 38) : 1'b1;

    task automatic check_field(input string name, input logic [DL_W-1:0] exp_v,
                               input logic [DL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: result word with nothing pending, expected none, got %h / %b",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                want = pending_results.pop_front();
                check_field("scheduled_time", want.sched,         o_m_tdata[63:0]);
                check_field("accepted",       want.accepted,      o_m_tuser[0]);
                check_field("cancel_found",   want.cancel_found,  o_m_tuser[1]);
                check_field("fired",          want.fired,         o_m_tuser[2]);
                check_field("fired_id",       want.fired_id,      o_m_tdata[79:64]);
                check_field("next_deadline",  want.next_deadline, o_m_tdata[143:80]);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time,
                     pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly pool ids so cancels hit; sometimes a live entry deep in the queue
    function automatic logic [15:0] pick_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3 && tq_count > 0)
            return 16'(tq_id[$urandom_range(0, tq_count - 1)]);
        else if (sel < 8)
            return 16'(id_pool[$urandom_range(0, 7)]);
        return 16'($urandom);
    endfunction

    // one well-formed word from the given mix, or a fully random one
    task automatic random_word(input int pct_sched, input int pct_tick, input int pct_cancel);
        int              roll;
        logic            absol;
        logic [DL_W-1:0] tval;
        logic [DL_W-1:0] dl;
        cur_now = cur_now + $urandom_range(0, 60);
        roll    = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 8) begin
            // noise: anything the fields allow
            send_word(ACT_W'($urandom_range(0, 3)), 16'($urandom), rand64(),
                      1'($urandom), rand64());
        end else if (roll < pct_sched) begin
            absol = 1'($urandom);
            case ($urandom_range(0, 9))
                0:       dl = last_deadline;                // tie with an earlier one
                1:       dl = rand64();
                2:       dl = cur_now;
                default: dl = cur_now + $urandom_range(0, 1000);
            endcase
            tval = absol ? dl : dl - cur_now;
            last_deadline = dl;
            send_word(ACT_SCHEDULE, pick_id(), tval, absol, cur_now);
        end else if (roll < pct_sched + pct_tick) begin
            send_word(ACT_TICK, pick_id(), rand64(), 1'($urandom), cur_now);
        end else if (roll < pct_sched + pct_tick + pct_cancel) begin
            send_word(ACT_CANCEL, pick_id(), rand64(), 1'($urandom), cur_now);
        end else begin
            send_word(ACT_UNUSED, pick_id(), rand64(), 1'($urandom), cur_now);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_and_edges();
        // empty queue: tick, cancel and the unused code change nothing
        send_word(ACT_TICK,   16'h0000, 64'd0, 1'b0, 64'd0);
        send_word(ACT_CANCEL, 16'hFFFF, 64'd0, 1'b0, 64'd0);
        send_word(ACT_UNUSED, 16'hFFFF, '1,    1'b1, '1);
        // ties keep arrival order; relative deadline lands at the head
        send_word(ACT_SCHEDULE, 16'hFFFF, 64'd100, 1'b1, 64'd0);
        send_word(ACT_SCHEDULE, 16'h0000, 64'd100, 1'b1, 64'd0);
        send_word(ACT_SCHEDULE, 16'h1234, 64'd50,  1'b0, 64'd20);
        // zero deadline: head reads 0 with a non-empty queue
        send_word(ACT_SCHEDULE, 16'h0007, 64'd0, 1'b1, 64'd5);
        send_word(ACT_TICK,     16'h0000, 64'd0, 1'b0, 64'd0);   // 0 > 0 fails
        send_word(ACT_TICK,     16'h0000, 64'd0, 1'b0, 64'd1);
        // delay wraps past 2^64
        send_word(ACT_SCHEDULE, 16'h00AA, 64'h20, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0);
        send_word(ACT_TICK,     16'h0000, 64'd0,  1'b0, 64'h11);
        // cancel hit on the later tie, then a miss
        send_word(ACT_CANCEL, 16'h0000, 64'd0, 1'b0, 64'd0);
        send_word(ACT_CANCEL, 16'h0000, 64'd0, 1'b0, 64'd0);
        // largest deadline and time
        send_word(ACT_SCHEDULE, 16'hFFFF, '1, 1'b1, '1);
        send_word(ACT_TICK,     16'h0000, '1, 1'b1, '1);
    endtask

    task automatic test_margin_edges();
        write_margin(20'd1000000);
        // pop the entry left at deadline 100 so the new one reaches the head
        send_word(ACT_TICK, 16'h0000, 64'd0, 1'b0, 64'd0);
        send_word(ACT_SCHEDULE, 16'h0101, 64'd5000000, 1'b1, 64'd0);
        send_word(ACT_TICK, 16'h0000, 64'd0, 1'b0, 64'd4000000);    // equal, holds
        send_word(ACT_TICK, 16'h0000, 64'd0, 1'b0, 64'd4000001);
        // now + margin wraps to a small value
        send_word(ACT_SCHEDULE, 16'h0202, 64'd999998, 1'b1, 64'd0);
        send_word(ACT_TICK, 16'h0000, 64'd0, 1'b0, '1);
        send_word(ACT_TICK, 16'h0000, 64'd0, 1'b0, '1);
    endtask

    task automatic test_random_mix(input int count, input int pct_sched,
                                   input int pct_tick, input int pct_cancel);
        repeat (count) random_word(pct_sched, pct_tick, pct_cancel);
    endtask

    task automatic test_no_stall_burst();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        test_random_mix(300, 45, 35, 17);
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    task automatic test_time_wrap();
        stop_source();
        cur_now = 64'hFFFF_FFFF_FFFF_8000 + $urandom_range(0, 4095);
        test_random_mix(350, 40, 35, 20);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int k = 2; k < 8; k++)
            id_pool[k] = ID_BITS'($urandom);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_and_edges();
        test_margin_edges();
        write_margin(20'd0);
        test_random_mix(400, 40, 35, 20);          // balanced
        write_margin(20'd1000000);
        test_random_mix(250, 70, 15, 12);          // fills the queue
        write_margin(20'd1);
        test_no_stall_burst();
        write_margin(RES_W'($urandom_range(0, 1000000)));
        test_random_mix(400, 30, 50, 17);          // drains the queue
        write_margin(20'd0);
        test_time_wrap();

        stop_source();
        $display("Sent %0d command words under %0d margin settings, checked %0d results.",
                 words_sent, n_margins, results_seen);
        $display("Saw %0d fires, %0d cancel hits and %0d full-queue rejects.",
                 n_fired, n_cancel_hits, n_full_reject);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
